// ----- src/facfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed ASCII command frame parser package
// Frame layout constants, character codes and the value parser state types.
// ----------------------------------------------------------------------------
package facfp_pkg;

  localparam int VALUE_CHARS = 6;

  localparam int POS_W = 4;
  localparam int MAG_W = 20;
  localparam int VAL_W = 16;
  localparam int CHR_W = 8;

  localparam logic [POS_W-1:0] POS_START = POS_W'(0);
  localparam logic [POS_W-1:0] POS_A     = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEP1  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_VAL   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_SEP2  = POS_W'(VALUE_CHARS + 3);
  localparam logic [POS_W-1:0] POS_B     = POS_W'(VALUE_CHARS + 4);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(VALUE_CHARS + 5);

  localparam logic [CHR_W-1:0] CHR_DOLLAR = 8'h24;
  localparam logic [CHR_W-1:0] CHR_COMMA  = 8'h2C;
  localparam logic [CHR_W-1:0] CHR_HASH   = 8'h23;
  localparam logic [CHR_W-1:0] CHR_PLUS   = 8'h2B;
  localparam logic [CHR_W-1:0] CHR_MINUS  = 8'h2D;
  localparam logic [CHR_W-1:0] CHR_ZERO   = 8'h30;
  localparam logic [CHR_W-1:0] CHR_NINE   = 8'h39;
  localparam logic [CHR_W-1:0] CHR_TAB    = 8'h09;
  localparam logic [CHR_W-1:0] CHR_CR     = 8'h0D;
  localparam logic [CHR_W-1:0] CHR_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [MAG_W-1:0]   magnitude;
    logic               negative;
  } parse_state_t;

  localparam parse_state_t PARSE_RESTART = '{phase: PH_SKIP, magnitude: '0, negative: 1'b0};

endpackage

// ----- src/facfp_value_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Value field character parser
// Advances the base 10 value parser by one character: whitespace skip,
// optional sign, then digit accumulation with a multiply by ten.
// ----------------------------------------------------------------------------
module facfp_value_parse (
  input  facfp_pkg::parse_state_t      state_i,
  input  logic [facfp_pkg::CHR_W-1:0]  char_i,
  output facfp_pkg::parse_state_t      state_o
);

  logic                        is_digit;
  logic                        is_space;
  logic [3:0]                  digit;
  logic [facfp_pkg::MAG_W+3:0] times_ten;
  logic [facfp_pkg::MAG_W+3:0] accum;

  assign is_digit  = char_i inside {[facfp_pkg::CHR_ZERO:facfp_pkg::CHR_NINE]};
  assign is_space  = char_i inside {[facfp_pkg::CHR_TAB:facfp_pkg::CHR_CR],
                                    facfp_pkg::CHR_SPACE};
  assign digit     = char_i[3:0];
  assign times_ten = {1'b0, state_i.magnitude, 3'b000} + {3'b000, state_i.magnitude, 1'b0};
  assign accum     = times_ten + {{facfp_pkg::MAG_W{1'b0}}, digit};

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      facfp_pkg::PH_SKIP: begin
        if (is_space) begin
          state_o.phase = facfp_pkg::PH_SKIP;
        end else if (char_i == facfp_pkg::CHR_PLUS) begin
          state_o.phase = facfp_pkg::PH_SIGN;
        end else if (char_i == facfp_pkg::CHR_MINUS) begin
          state_o.negative = 1'b1;
          state_o.phase    = facfp_pkg::PH_SIGN;
        end else if (is_digit) begin
          state_o.magnitude = {{(facfp_pkg::MAG_W-4){1'b0}}, digit};
          state_o.phase     = facfp_pkg::PH_DIGITS;
        end else begin
          state_o.phase = facfp_pkg::PH_DONE;
        end
      end
      facfp_pkg::PH_SIGN: begin
        if (is_digit) begin
          state_o.magnitude = {{(facfp_pkg::MAG_W-4){1'b0}}, digit};
          state_o.phase     = facfp_pkg::PH_DIGITS;
        end else begin
          state_o.magnitude = '0;
          state_o.phase     = facfp_pkg::PH_DONE;
        end
      end
      facfp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          state_o.magnitude = accum[facfp_pkg::MAG_W-1:0];
        end else begin
          state_o.phase = facfp_pkg::PH_DONE;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ----- src/fixed_ascii_command_frame_parser_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed ASCII command frame parser
// Counts bytes through fixed frames, checks the delimiters, parses the signed
// decimal value on the fly and emits one result transaction per frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, limited by the single frame state update;
// the result is registered and appears in the cycle after the last byte of
// a frame is taken. The output register lets every byte but the last of a
// frame be taken while a result waits for tready; the last byte waits.
// Reset: asynchronous, active low; position, delimiter flag and parser clear,
// and the held values return to ASCII zero, zero and ASCII zero.

module fixed_ascii_command_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] command_a, [23:8] command_value,
                                      // [31:24] command_b
  output logic        m_axis_tuser    // [0] frame_ok
);

  logic [facfp_pkg::POS_W-1:0] pos_q, pos_d;
  logic                        good_q, good_d;
  facfp_pkg::parse_state_t     parse_q, parse_d, parse_next;
  logic [facfp_pkg::CHR_W-1:0] pend_a_q, pend_a_d;
  logic [facfp_pkg::CHR_W-1:0] pend_b_q, pend_b_d;
  logic [facfp_pkg::CHR_W-1:0] held_a_q, held_a_d;
  logic [facfp_pkg::CHR_W-1:0] held_b_q, held_b_d;
  logic [facfp_pkg::VAL_W-1:0] held_val_q, held_val_d;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 out_data_q, out_data_d;
  logic                        out_ok_q, out_ok_d;

  logic                        accept;
  logic                        in_value;
  logic                        frame_ok;
  logic [facfp_pkg::VAL_W-1:0] new_value;

  assign s_axis_tready = !out_valid_q || m_axis_tready || (pos_q != facfp_pkg::POS_LAST);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_value      = (pos_q >= facfp_pkg::POS_VAL) && (pos_q < facfp_pkg::POS_SEP2);

  facfp_value_parse u_value_parse (
    .state_i (parse_q),
    .char_i  (s_axis_tdata),
    .state_o (parse_next)
  );

  assign new_value = parse_q.negative ?
                     (facfp_pkg::VAL_W'(0) - parse_q.magnitude[facfp_pkg::VAL_W-1:0]) :
                     parse_q.magnitude[facfp_pkg::VAL_W-1:0];
  assign frame_ok  = good_q && (s_axis_tdata == facfp_pkg::CHR_HASH);

  always_comb begin
    pos_d      = pos_q;
    good_d     = good_q;
    parse_d    = parse_q;
    pend_a_d   = pend_a_q;
    pend_b_d   = pend_b_q;
    held_a_d   = held_a_q;
    held_b_d   = held_b_q;
    held_val_d = held_val_q;
    out_data_d = out_data_q;
    out_ok_d   = out_ok_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (accept) begin
      pos_d = pos_q + facfp_pkg::POS_W'(1);
      if (pos_q == facfp_pkg::POS_START) begin
        if (s_axis_tdata != facfp_pkg::CHR_DOLLAR) begin
          good_d = 1'b0;
        end
      end else if (pos_q == facfp_pkg::POS_A) begin
        pend_a_d = s_axis_tdata;
      end else if (pos_q == facfp_pkg::POS_SEP1) begin
        if (s_axis_tdata != facfp_pkg::CHR_COMMA) begin
          good_d = 1'b0;
        end
      end else if (in_value) begin
        parse_d = parse_next;
      end else if (pos_q == facfp_pkg::POS_SEP2) begin
        if (s_axis_tdata != facfp_pkg::CHR_COMMA) begin
          good_d = 1'b0;
        end
      end else if (pos_q == facfp_pkg::POS_B) begin
        pend_b_d = s_axis_tdata;
      end else begin
        pos_d   = facfp_pkg::POS_START;
        good_d  = 1'b1;
        parse_d = facfp_pkg::PARSE_RESTART;
        out_valid_d = 1'b1;
        out_ok_d    = frame_ok;
        if (frame_ok) begin
          held_a_d   = pend_a_q;
          held_b_d   = pend_b_q;
          held_val_d = new_value;
          out_data_d = {pend_b_q, new_value, pend_a_q};
        end else begin
          out_data_d = {held_b_q, held_val_q, held_a_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= facfp_pkg::POS_START;
      good_q      <= 1'b1;
      parse_q     <= facfp_pkg::PARSE_RESTART;
      held_a_q    <= facfp_pkg::CHR_ZERO;
      held_b_q    <= facfp_pkg::CHR_ZERO;
      held_val_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      good_q      <= good_d;
      parse_q     <= parse_d;
      held_a_q    <= held_a_d;
      held_b_q    <= held_b_d;
      held_val_q  <= held_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_a_q   <= pend_a_d;
    pend_b_q   <= pend_b_d;
    out_data_q <= out_data_d;
    out_ok_q   <= out_ok_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

// ----- src/facfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed ASCII command frame parser checker
// Port level properties of the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module facfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [facfp_pkg::POS_W-1:0] count_q;
  logic [31:0]                 last_data_q;
  logic                        in_acc;
  logic                        out_acc;
  logic                        frame_end;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign frame_end = count_q == facfp_pkg::POS_LAST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= facfp_pkg::POS_START;
      last_data_q <= {facfp_pkg::CHR_ZERO, 16'h0000, facfp_pkg::CHR_ZERO};
    end else begin
      if (in_acc) begin
        count_q <= frame_end ? facfp_pkg::POS_START : count_q + facfp_pkg::POS_W'(1);
      end
      if (out_acc) begin
        last_data_q <= m_axis_tdata;
      end
    end
  end

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The last byte of a frame produces a result in the next cycle.
  a_frame_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_end |=> m_axis_tvalid)
    else $error("missing result at end of frame");

  // Bytes inside a frame produce no result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !frame_end && !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
    else $error("result without end of frame");

  // A bad frame repeats the values of the previous result.
  a_bad_frame_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == last_data_q)
    else $error("bad frame changed the held values");

  // The parser takes one byte per cycle while the result side is free.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind fixed_ascii_command_frame_parser_core facfp_checker u_facfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
